FILE: rtl/core/lfu_sector_cache_tags_top_defines.svh
// Assertion macros used by the back part of the cache tag store.
`ifndef LFU_SECTOR_CACHE_TAGS_TOP_DEFINES_SVH
`define LFU_SECTOR_CACHE_TAGS_TOP_DEFINES_SVH

// Checks an implication on every rising clock edge outside reset.
`define LSCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Checks a next-cycle implication on every rising clock edge outside reset.
`define LSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

FILE: rtl/core/lsct_pkg.sv
package lsct_pkg;

	localparam int Entries = 64;
	localparam int OwnerBits = 16;
	localparam int SlotBits = $clog2(Entries);
	localparam int CntBits = $clog2(Entries + 1);
	localparam int QDepth = 2;

	localparam logic [1:0] CmdRead = 2'd0;
	localparam logic [1:0] CmdWrite = 2'd1;
	localparam logic [1:0] CmdTick = 2'd2;
	localparam logic [1:0] CmdFlush = 2'd3;

	localparam logic [1:0] KindHit = 2'd0;
	localparam logic [1:0] KindFill = 2'd1;
	localparam logic [1:0] KindWb = 2'd2;
	localparam logic [1:0] KindNone = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] owner_id;
		logic [31:0] sector;
		logic [31:0] tick_count;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  slot;
		logic [15:0] result_owner;
		logic [31:0] result_sector;
		logic        last;
	} out_item_t;

	// Classified job handed from the front part to the back part.
	typedef struct packed {
		logic        is_access;
		logic        is_write;
		logic        do_wb;
		logic [15:0] owner;
		logic [31:0] sector;
	} job_t;

endpackage

FILE: rtl/core/lfu_sector_cache_tags_top.sv
// Tag store of a 64-entry fully associative disk sector cache with LFU replacement and
// write-back. Each transaction on the push side yields one or more result transactions
// on the pop side, the final one flagged by last. A front part classifies the command
// and, for ticks, finds tick_count modulo the period with a bit-serial divider;
// a two-deep queue then hands the job to a back part that walks the tag memory one
// entry per cycle, pausing to send each write-back, through a registered read port.
// An access takes one full walk plus decision and fill; a tick or flush takes a walk
// plus the sending of each dirty entry written back. A result that waits on pop holds
// the back part. No clearing pass is needed after reset: valid and dirty bits live in
// flip-flops.
module lfu_sector_cache_tags_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lsct_pkg::in_item_t  in_item,
	output logic                empty,
	input  logic                pop,
	output lsct_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic [15:0] period_q;
	logic f_valid, f_ready, b_valid, b_ready;
	lsct_pkg::job_t f_job, b_job;

	// The period register is always ready to take a write transaction.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 16'd100;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	lsct_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_item(in_item),
		.period(period_q), .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	lsct_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	lsct_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_ready(b_ready),
		.job(b_job), .empty(empty), .pop(pop), .out_item(out_item)
	);

endmodule

FILE: rtl/core/lsct_front.sv
module lsct_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lsct_pkg::in_item_t  in_item,
	input  logic [15:0]         period,
	output logic                job_valid,
	input  logic                job_ready,
	output lsct_pkg::job_t      job
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_SEND = 3'b100
	} fstate_t;

	fstate_t state_q;
	lsct_pkg::job_t job_q;
	logic [31:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] per_q;
	logic [5:0] bit_q;
	logic [16:0] trial;

	assign trial = {rem_q, num_q[31]} - {1'b0, per_q};
	assign full = (state_q != F_IDLE);
	assign job_valid = (state_q == F_SEND);
	assign job = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						if (in_item.command == lsct_pkg::CmdTick && period != 16'd0) begin
							state_q <= F_DIV;
						end else begin
							state_q <= F_SEND;
						end
					end
				end
				F_DIV: begin
					if (bit_q == 6'd31) begin
						state_q <= F_SEND;
					end
				end
				F_SEND: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Restoring division, one quotient bit per cycle; only the remainder matters.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			job_q.is_access <= (in_item.command == lsct_pkg::CmdRead) ||
				(in_item.command == lsct_pkg::CmdWrite);
			job_q.is_write <= (in_item.command == lsct_pkg::CmdWrite);
			job_q.do_wb <= (in_item.command == lsct_pkg::CmdFlush);
			job_q.owner <= in_item.owner_id;
			job_q.sector <= in_item.sector;
			num_q <= in_item.tick_count;
			rem_q <= 16'd0;
			per_q <= period;
			bit_q <= 6'd0;
		end else if (state_q == F_DIV) begin
			num_q <= {num_q[30:0], 1'b0};
			bit_q <= bit_q + 6'd1;
			if (!trial[16]) begin
				rem_q <= trial[15:0];
				if (bit_q == 6'd31) begin
					job_q.do_wb <= (trial[15:0] == 16'd0);
				end
			end else begin
				rem_q <= {rem_q[14:0], num_q[31]};
				if (bit_q == 6'd31) begin
					job_q.do_wb <= ({rem_q[14:0], num_q[31]} == 16'd0);
				end
			end
		end
	end

endmodule

FILE: rtl/core/lsct_queue.sv
module lsct_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  lsct_pkg::job_t  wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output lsct_pkg::job_t  rd_data
);

	localparam int PtrBits = $clog2(lsct_pkg::QDepth);

	lsct_pkg::job_t mem_q [lsct_pkg::QDepth];
	logic [PtrBits-1:0] wptr_q;
	logic [PtrBits-1:0] rptr_q;
	logic [PtrBits:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != (PtrBits + 1)'(lsct_pkg::QDepth));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (PtrBits + 1)'(do_wr) - (PtrBits + 1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

endmodule

FILE: rtl/core/lsct_back.sv
`include "lfu_sector_cache_tags_top_defines.svh"

module lsct_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  lsct_pkg::job_t      job,
	output logic                empty,
	input  logic                pop,
	output lsct_pkg::out_item_t out_item
);

	localparam int SB = lsct_pkg::SlotBits;
	localparam int CB = lsct_pkg::CntBits;
	localparam logic [CB-1:0] NumEntries = CB'(lsct_pkg::Entries);

	typedef enum logic [6:0] {
		B_IDLE  = 7'b0000001,
		B_SCAN  = 7'b0000010,
		B_DEC   = 7'b0000100,
		B_VICT  = 7'b0001000,
		B_FILL  = 7'b0010000,
		B_WBSC  = 7'b0100000,
		B_OUT   = 7'b1000000
	} bstate_t;

	bstate_t state_q;
	bstate_t after_q;
	lsct_pkg::job_t job_q;

	logic [lsct_pkg::Entries-1:0] valid_q;
	logic [lsct_pkg::Entries-1:0] dirty_q;
	logic [lsct_pkg::OwnerBits-1:0] own_mem [lsct_pkg::Entries];
	logic [31:0] sec_mem [lsct_pkg::Entries];
	logic [15:0] cnt_mem [lsct_pkg::Entries];

	logic [CB-1:0] idx_q;
	logic [SB-1:0] idx_s;
	logic [SB-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic [lsct_pkg::OwnerBits-1:0] rd_own_s1;
	logic [31:0] rd_sec_s1;
	logic [15:0] rd_cnt_s1;

	logic hit_q;
	logic [SB-1:0] hit_slot_q;
	logic [15:0] best_cnt_q;
	logic [SB-1:0] best_slot_q;
	logic free_q;
	logic [SB-1:0] free_slot_q;
	logic found_wb_q;
	logic out_v_q;
	lsct_pkg::out_item_t out_q;
	lsct_pkg::out_item_t res_q;
	lsct_pkg::out_item_t wb_hold_q;

	logic [lsct_pkg::OwnerBits-1:0] owner_m;
	logic [SB-1:0] pend_slot_q;
	logic [15:0] pend_cnt_q;
	logic pend_cnt_w_q;

	assign idx_s = idx_q[SB-1:0];
	assign owner_m = job_q.owner[lsct_pkg::OwnerBits-1:0];
	assign job_ready = (state_q == B_IDLE);
	assign empty = !out_v_q;
	assign out_item = out_q;

	always_ff @(posedge clk) begin
		rd_own_s1 <= own_mem[idx_s];
		rd_sec_s1 <= sec_mem[idx_s];
		rd_cnt_s1 <= cnt_mem[idx_s];
		rd_idx_s1 <= idx_s;
		if (pend_cnt_w_q) begin
			cnt_mem[pend_slot_q] <= pend_cnt_q;
		end
		if (state_q == B_FILL && !out_v_q) begin
			own_mem[pend_slot_q] <= owner_m;
			sec_mem[pend_slot_q] <= job_q.sector;
			cnt_mem[pend_slot_q] <= 16'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			after_q <= B_IDLE;
			job_q <= '0;
			valid_q <= '0;
			dirty_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			res_q <= '0;
			wb_hold_q <= '0;
			rd_vld_s1 <= 1'b0;
			pend_cnt_w_q <= 1'b0;
			pend_slot_q <= '0;
			pend_cnt_q <= '0;
			idx_q <= '0;
			hit_q <= 1'b0;
			hit_slot_q <= '0;
			free_q <= 1'b0;
			free_slot_q <= '0;
			found_wb_q <= 1'b0;
			best_cnt_q <= '0;
			best_slot_q <= '0;
		end else begin
			pend_cnt_w_q <= 1'b0;
			if (out_v_q && pop) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (job_valid) begin
						job_q <= job;
						idx_q <= '0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						found_wb_q <= 1'b0;
						best_cnt_q <= 16'hFFFF;
						best_slot_q <= '0;
						if (job.is_access) begin
							state_q <= B_SCAN;
						end else if (job.do_wb) begin
							state_q <= B_WBSC;
						end else begin
							res_q <= '{lsct_pkg::KindNone, 6'd0, 16'd0, 32'd0, 1'b1};
							after_q <= B_IDLE;
							state_q <= B_OUT;
						end
					end
				end
				B_SCAN: begin
					// The compare stage sees the entry addressed in the previous cycle.
					if (idx_q != NumEntries) begin
						idx_q <= idx_q + 1'b1;
					end
					rd_vld_s1 <= (idx_q != NumEntries);
					if (rd_vld_s1) begin
						if (valid_q[rd_idx_s1] && !hit_q &&
							rd_own_s1 == owner_m && rd_sec_s1 == job_q.sector) begin
							hit_q <= 1'b1;
							hit_slot_q <= rd_idx_s1;
							pend_cnt_q <= rd_cnt_s1;
						end
						if (!valid_q[rd_idx_s1] && !free_q) begin
							free_q <= 1'b1;
							free_slot_q <= rd_idx_s1;
						end
						if (valid_q[rd_idx_s1] && (rd_idx_s1 == '0 || rd_cnt_s1 < best_cnt_q)) begin
							best_cnt_q <= rd_cnt_s1;
							best_slot_q <= rd_idx_s1;
						end
					end
					if (!rd_vld_s1 && idx_q == NumEntries) begin
						state_q <= B_DEC;
					end
				end
				B_DEC: begin
					if (hit_q) begin
						if (pend_cnt_q != 16'hFFFF) begin
							pend_cnt_q <= pend_cnt_q + 16'd1;
							pend_slot_q <= hit_slot_q;
							pend_cnt_w_q <= 1'b1;
						end
						if (job_q.is_write) begin
							dirty_q[hit_slot_q] <= 1'b1;
						end
						res_q <= '{lsct_pkg::KindHit, 6'(hit_slot_q), 16'(owner_m),
							job_q.sector, 1'b1};
						after_q <= B_IDLE;
						state_q <= B_OUT;
					end else if (free_q) begin
						pend_slot_q <= free_slot_q;
						state_q <= B_FILL;
					end else begin
						pend_slot_q <= best_slot_q;
						idx_q <= CB'(best_slot_q);
						state_q <= B_VICT;
					end
				end
				B_VICT: begin
					// Wait for the victim's stored tag to arrive.
					if (rd_idx_s1 == pend_slot_q) begin
						if (dirty_q[pend_slot_q]) begin
							res_q <= '{lsct_pkg::KindWb, 6'(pend_slot_q), 16'(rd_own_s1),
								rd_sec_s1, 1'b0};
							after_q <= B_FILL;
							state_q <= B_OUT;
						end else begin
							state_q <= B_FILL;
						end
					end
				end
				B_FILL: begin
					if (!out_v_q) begin
						valid_q[pend_slot_q] <= 1'b1;
						dirty_q[pend_slot_q] <= job_q.is_write;
						out_q <= '{lsct_pkg::KindFill, 6'(pend_slot_q), 16'(owner_m),
							job_q.sector, 1'b1};
						out_v_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				B_WBSC: begin
					if (idx_q != NumEntries) begin
						idx_q <= idx_q + 1'b1;
					end
					rd_vld_s1 <= (idx_q != NumEntries);
					if (rd_vld_s1 && valid_q[rd_idx_s1] && dirty_q[rd_idx_s1]) begin
						// Each write-back is held until the next one turns up, so that
						// the final one of the walk can carry last.
						dirty_q[rd_idx_s1] <= 1'b0;
						found_wb_q <= 1'b1;
						wb_hold_q <= '{lsct_pkg::KindWb, 6'(rd_idx_s1), 16'(rd_own_s1),
							rd_sec_s1, 1'b0};
						if (found_wb_q) begin
							// Send the held one and resume the walk after this entry.
							res_q <= wb_hold_q;
							idx_q <= CB'(rd_idx_s1) + 1'b1;
							rd_vld_s1 <= 1'b0;
							after_q <= B_WBSC;
							state_q <= B_OUT;
						end
					end else if (!rd_vld_s1 && idx_q == NumEntries) begin
						if (found_wb_q) begin
							res_q <= '{wb_hold_q.kind, wb_hold_q.slot, wb_hold_q.result_owner,
								wb_hold_q.result_sector, 1'b1};
						end else begin
							res_q <= '{lsct_pkg::KindNone, 6'd0, 16'd0, 32'd0, 1'b1};
						end
						after_q <= B_IDLE;
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (!out_v_q) begin
						out_q <= res_q;
						out_v_q <= 1'b1;
						state_q <= after_q;
						rd_vld_s1 <= 1'b0;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`LSCT_ASSERT_IMPL(a_ready_idle, clk, arst_n, job_ready, !out_v_q || state_q == B_IDLE)
	`LSCT_ASSERT_NEXT(a_fill_valid, clk, arst_n, state_q == B_FILL && !out_v_q,
		valid_q[pend_slot_q])
	`LSCT_ASSERT_IMPL(a_out_hold, clk, arst_n, state_q == B_OUT && out_v_q, !empty)

endmodule

FILE: sim/tb_lfu_sector_cache_tags_top.sv
`timescale 1ns / 1ps

module tb_lfu_sector_cache_tags_top;

	localparam int NumSlots = 64;
	localparam int PhaseItems = 90;
	localparam int PoolSize = 90;
	localparam int DrainCycles = 300;
	localparam int StallLimit = 20000;

	// Shadow copy of the tag store. Every accepted request is played through it,
	// and the result transactions it predicts wait in order in expected_results.
	class sector_tag_scoreboard;
		bit          slot_valid[NumSlots];
		bit [15:0]   slot_owner[NumSlots];
		bit [31:0]   slot_sector[NumSlots];
		bit [15:0]   slot_uses[NumSlots];
		bit          slot_dirty[NumSlots];
		bit [15:0]   period;
		lsct_pkg::out_item_t expected_results[$];
		int          errors;
		int          results_checked;
		int          evictions;
		int          write_backs;

		function new();
			period = 16'd100;
		endfunction

		function void expect_result(logic [1:0] kind, int slot, logic [15:0] owner,
				logic [31:0] sector, logic last);
			lsct_pkg::out_item_t r;
			r.kind = kind;
			r.slot = slot[5:0];
			r.result_owner = owner;
			r.result_sector = sector;
			r.last = last;
			expected_results.push_back(r);
		endfunction

		// Writes back every dirty entry in ascending order; a lone idle result if none.
		function void write_back_dirty();
			int n;
			n = 0;
			for (int i = 0; i < NumSlots; i++) begin
				if (slot_valid[i] && slot_dirty[i]) begin
					expect_result(lsct_pkg::KindWb, i, slot_owner[i], slot_sector[i], 1'b0);
					slot_dirty[i] = 1'b0;
					n++;
				end
			end
			write_backs += n;
			if (n == 0)
				expect_result(lsct_pkg::KindNone, 0, '0, '0, 1'b1);
			else
				expected_results[expected_results.size() - 1].last = 1'b1;
		endfunction

		function void note_input(lsct_pkg::in_item_t it);
			int victim;
			bit is_write;
			is_write = (it.command == lsct_pkg::CmdWrite);
			if (it.command == lsct_pkg::CmdTick) begin
				if (period == 0 || (it.tick_count % period) != 0)
					expect_result(lsct_pkg::KindNone, 0, '0, '0, 1'b1);
				else
					write_back_dirty();
				return;
			end
			if (it.command == lsct_pkg::CmdFlush) begin
				write_back_dirty();
				return;
			end
			for (int i = 0; i < NumSlots; i++) begin
				if (slot_valid[i] && slot_owner[i] == it.owner_id &&
						slot_sector[i] == it.sector) begin
					if (slot_uses[i] != 16'hFFFF)
						slot_uses[i]++;
					if (is_write)
						slot_dirty[i] = 1'b1;
					expect_result(lsct_pkg::KindHit, i, it.owner_id, it.sector, 1'b1);
					return;
				end
			end
			// Miss: lowest free slot first, otherwise the least used entry.
			victim = -1;
			for (int i = 0; i < NumSlots; i++) begin
				if (!slot_valid[i]) begin
					victim = i;
					break;
				end
			end
			if (victim < 0) begin
				victim = 0;
				for (int i = 1; i < NumSlots; i++)
					if (slot_uses[i] < slot_uses[victim])
						victim = i;
				evictions++;
				if (slot_dirty[victim]) begin
					expect_result(lsct_pkg::KindWb, victim, slot_owner[victim],
						slot_sector[victim], 1'b0);
					write_backs++;
				end
			end
			slot_valid[victim] = 1'b1;
			slot_owner[victim] = it.owner_id;
			slot_sector[victim] = it.sector;
			slot_uses[victim] = '0;
			slot_dirty[victim] = is_write;
			expect_result(lsct_pkg::KindFill, victim, it.owner_id, it.sector, 1'b1);
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(lsct_pkg::out_item_t got);
			lsct_pkg::out_item_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = expected_results.pop_front();
			results_checked++;
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
			if (got.slot !== want.slot)
				report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
			if (got.result_owner !== want.result_owner)
				report($sformatf("owner %h, expected %h", got.result_owner,
					want.result_owner));
			if (got.result_sector !== want.result_sector)
				report($sformatf("sector %h, expected %h", got.result_sector,
					want.result_sector));
			if (got.last !== want.last)
				report($sformatf("last %b, expected %b", got.last, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	lsct_pkg::in_item_t  in_item = '0;
	logic        empty;
	logic        pop = 1'b0;
	lsct_pkg::out_item_t out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	sector_tag_scoreboard tags = new();

	// Sender pacing: bursts of back-to-back requests separated by idle gaps.
	int burst_left = 0;
	int items_sent = 0;
	int stall_cycles = 0;
	int cycle_count = 0;

	// Addresses reused across the random part so that hits, a full store and
	// evictions all occur. A little more than the store can hold.
	logic [15:0] pool_owner[PoolSize];
	logic [31:0] pool_sector[PoolSize];

	always #5 clk = ~clk;

	lfu_sector_cache_tags_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Result side. Every result transaction is checked as it is taken. The stall
	// pattern cycles through phases: always ready, mostly ready and mostly stalled.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && pop && !empty)
			tags.check_result(out_item);
		case ((cycle_count / 700) % 3)
			0: begin
				pop <= 1'b1;
			end
			1: begin
				pop <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				pop <= ($urandom_range(0, 9) < 3);
			end
		endcase
	end

	// Watchdog: any transaction on any channel resets the count of idle cycles.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= StallLimit) begin
			$display("lfu_sector_cache_tags_top regression: fail");
			$finish;
		end
	end

	// Presents one request and holds it until the block takes it. A gap that
	// follows lowers push only after the transaction, never in the same step
	// that raises it again.
	task automatic send_request(lsct_pkg::in_item_t it);
		int gap;
		push <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (full);
		tags.note_input(it);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 12);
			gap = $urandom_range(1, 9);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_access(logic [1:0] cmd, logic [15:0] owner, logic [31:0] sector);
		lsct_pkg::in_item_t it;
		it.command = cmd;
		it.owner_id = owner;
		it.sector = sector;
		it.tick_count = $urandom;
		send_request(it);
	endtask

	task automatic send_timer(logic [1:0] cmd, logic [31:0] ticks);
		lsct_pkg::in_item_t it;
		it.command = cmd;
		it.owner_id = 16'($urandom);
		it.sector = $urandom;
		it.tick_count = ticks;
		send_request(it);
	endtask

	// Waits for every outstanding result, then for the back part to go quiet.
	task automatic wait_idle();
		while (tags.expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_period(logic [15:0] value);
		push <= 1'b0;
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		tags.period = value;
	endtask

	// A tick value that hits a multiple of the period about half the time.
	function automatic logic [31:0] pick_tick();
		logic [31:0] k;
		if (tags.period != 0 && $urandom_range(0, 1) == 1) begin
			k = $urandom_range(0, 32'hFFFF_FFFF / tags.period);
			return k * tags.period;
		end
		return $urandom;
	endfunction

	task automatic refresh_pool(int count);
		int idx;
		for (int i = 0; i < count; i++) begin
			idx = $urandom_range(0, PoolSize - 1);
			pool_owner[idx] = 16'($urandom);
			pool_sector[idx] = $urandom;
		end
	endtask

	// One phase of random traffic. Most items are accesses to the pool, so the
	// store fills and both clean and dirty victims get evicted; a few are accesses
	// to fresh addresses, ticks and flushes.
	task automatic random_phase(int count);
		int pick;
		int idx;
		logic [1:0] cmd;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			cmd = ($urandom_range(0, 2) == 0) ? lsct_pkg::CmdWrite : lsct_pkg::CmdRead;
			if (pick < 78) begin
				idx = $urandom_range(0, PoolSize - 1);
				send_access(cmd, pool_owner[idx], pool_sector[idx]);
			end else if (pick < 86) begin
				send_access(cmd, 16'($urandom), $urandom);
			end else if (pick < 96) begin
				send_timer(lsct_pkg::CmdTick, pick_tick());
			end else begin
				send_timer(lsct_pkg::CmdFlush, $urandom);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < PoolSize; i++) begin
			pool_owner[i] = 16'($urandom);
			pool_sector[i] = $urandom;
		end
		pool_owner[0] = 16'h0000;
		pool_sector[0] = 32'h0000_0000;
		pool_owner[1] = 16'hFFFF;
		pool_sector[1] = 32'hFFFF_FFFF;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset period of 100: fills into free slots, hits,
		// write marking, flushes with and without dirty entries, and ticks on and
		// off a multiple of the period.
		send_access(lsct_pkg::CmdRead, 16'h0000, 32'h0000_0000);
		send_access(lsct_pkg::CmdRead, 16'h0000, 32'h0000_0000);
		send_access(lsct_pkg::CmdWrite, 16'h0000, 32'h0000_0000);
		send_access(lsct_pkg::CmdWrite, 16'hFFFF, 32'hFFFF_FFFF);
		send_access(lsct_pkg::CmdRead, 16'hFFFF, 32'hFFFF_FFFF);
		send_access(lsct_pkg::CmdRead, 16'hFFFF, 32'h0000_0000);
		send_access(lsct_pkg::CmdRead, 16'h0000, 32'hFFFF_FFFF);
		send_timer(lsct_pkg::CmdFlush, 32'h0);
		send_timer(lsct_pkg::CmdFlush, 32'hFFFF_FFFF);
		send_access(lsct_pkg::CmdWrite, 16'hAAAA, 32'h5555_5555);
		send_timer(lsct_pkg::CmdTick, 32'd1);
		send_timer(lsct_pkg::CmdTick, 32'hFFFF_FFFF);
		send_timer(lsct_pkg::CmdTick, 32'd0);
		send_access(lsct_pkg::CmdWrite, 16'h5555, 32'hAAAA_AAAA);
		send_timer(lsct_pkg::CmdTick, 32'd4200);
		send_timer(lsct_pkg::CmdTick, 32'd4200);
		send_access(lsct_pkg::CmdWrite, 16'h5555, 32'hAAAA_AAAA);

		random_phase(PhaseItems);

		// Every tick writes back with a period of one.
		write_period(16'd1);
		send_timer(lsct_pkg::CmdTick, 32'hFFFF_FFFF);
		refresh_pool(20);
		random_phase(PhaseItems);

		write_period(16'hFFFF);
		send_timer(lsct_pkg::CmdTick, 32'hFFFE_0001);
		refresh_pool(20);
		random_phase(PhaseItems);

		// A zero period turns tick write-back off entirely.
		write_period(16'd0);
		send_timer(lsct_pkg::CmdTick, 32'd0);
		refresh_pool(20);
		random_phase(PhaseItems);

		write_period(16'($urandom_range(2, 40)));
		refresh_pool(20);
		random_phase(PhaseItems);

		push <= 1'b0;
		wait_idle();

		$display("Sent %0d requests and checked %0d results across five period settings.",
			items_sent, tags.results_checked);
		$display("Store saw %0d evictions and %0d write-backs; %0d mismatches.",
			tags.evictions, tags.write_backs, tags.errors);
		if (tags.errors == 0 && tags.expected_results.size() == 0)
			$display("lfu_sector_cache_tags_top regression: pass");
		else
			$display("lfu_sector_cache_tags_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/lsct_pkg.sv
rtl/core/lsct_front.sv
rtl/core/lsct_queue.sv
rtl/core/lsct_back.sv
rtl/core/lfu_sector_cache_tags_top.sv
sim/tb_lfu_sector_cache_tags_top.sv
